@@ sv/crpa_pkg.sv @@
// Shared types, codes and constants of the color pair allocator.
package crpa_pkg;

    localparam int TABLE_SLOTS_DEF = 64;

    localparam int PAIR_W   = 7;
    localparam int COLOR_W  = 9;
    localparam int REFS_W   = 16;
    localparam int STATUS_W = 3;
    localparam int FUNC_W   = 2;

    typedef logic signed [COLOR_W-1:0] color_t;
    typedef logic [PAIR_W-1:0]         pair_t;
    typedef logic [REFS_W-1:0]         refs_t;

    localparam color_t TERM_DEFAULT_COLOR = -9'sd2;
    localparam refs_t  REFS_MAX           = 16'hFFFF;
    localparam pair_t  MAX_PAIRS_RESET    = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_LOOKUP  = 2'd2,
        FUNC_COMBINE = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED    = 3'd0,
        ST_NEW       = 3'd1,
        ST_FULL      = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_HELD      = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_NORMAL    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_MATCH  = 2'd1,
        S_UPDATE = 2'd2
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic evaluate;
        logic commit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

@@ sv/crpa_ctrl.sv @@
// Controller state machine that sequences capture, match and update of each word.
module crpa_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  crpa_pkg::dp_status_t  sts,
    output crpa_pkg::ctl_cmd_t    cmd
);

    crpa_pkg::ctl_state_t state_reg;
    crpa_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crpa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.evaluate = 1'b0;
        cmd.commit   = 1'b0;
        in_stall     = 1'b1;
        case (state_reg)
            crpa_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = crpa_pkg::S_MATCH;
                end
            end
            crpa_pkg::S_MATCH:
            begin
                cmd.evaluate = 1'b1;
                state_next   = crpa_pkg::S_UPDATE;
            end
            crpa_pkg::S_UPDATE:
            begin
                // Hold the table update until the result register can take the word.
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = crpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = crpa_pkg::S_IDLE;
            end
        endcase
    end

    a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == crpa_pkg::S_MATCH))
        else $error("accepted word did not move to the match step");

    a_match_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crpa_pkg::S_MATCH) |=> (state_reg == crpa_pkg::S_UPDATE))
        else $error("match step not followed by update step");

endmodule

@@ sv/crpa_datapath.sv @@
// Datapath: slot compare cells, pair and count memories, encoders, result register.
module crpa_datapath
#(
    parameter int TABLE_SLOTS = crpa_pkg::TABLE_SLOTS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  crpa_pkg::ctl_cmd_t                   cmd,
    output crpa_pkg::dp_status_t                 sts,
    input  logic                                 cfg_wr_en,
    input  logic [crpa_pkg::PAIR_W-1:0]          cfg_wr_data,
    input  logic [crpa_pkg::FUNC_W-1:0]          func,
    input  logic signed [crpa_pkg::COLOR_W-1:0]  fore_color,
    input  logic signed [crpa_pkg::COLOR_W-1:0]  back_color,
    input  logic [crpa_pkg::PAIR_W-1:0]          pair_a,
    input  logic [crpa_pkg::PAIR_W-1:0]          pair_b,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [crpa_pkg::PAIR_W-1:0]          pair_index,
    output logic signed [crpa_pkg::COLOR_W-1:0]  fore_out,
    output logic signed [crpa_pkg::COLOR_W-1:0]  back_out,
    output logic [crpa_pkg::STATUS_W-1:0]        status
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [8:0] SLOTS9 = 9'(TABLE_SLOTS);

    typedef logic [IDX_W-1:0] idx_t;

    // ---------------- storage ----------------
    logic [TABLE_SLOTS-1:0] valid_reg;
    crpa_pkg::color_t       cell_fore_reg [TABLE_SLOTS];
    crpa_pkg::color_t       cell_back_reg [TABLE_SLOTS];
    crpa_pkg::color_t       mem_fore [TABLE_SLOTS];
    crpa_pkg::color_t       mem_back [TABLE_SLOTS];
    crpa_pkg::refs_t        mem_refs [TABLE_SLOTS];
    crpa_pkg::pair_t        piu_reg;
    crpa_pkg::pair_t        piu_next;
    crpa_pkg::pair_t        max_pairs_reg;

    // ---------------- captured word ----------------
    crpa_pkg::func_t  func_reg;
    crpa_pkg::color_t fg_reg;
    crpa_pkg::color_t bg_reg;
    crpa_pkg::pair_t  pa_reg;
    crpa_pkg::pair_t  pb_reg;
    crpa_pkg::color_t rd_fore_reg;
    crpa_pkg::color_t rd_back_reg;

    // ---------------- match results ----------------
    crpa_pkg::color_t ev_fg_reg;
    crpa_pkg::color_t ev_bg_reg;
    logic             hit_reg;
    idx_t             hit_idx_reg;
    logic             free_ok_reg;
    idx_t             free_idx_reg;
    logic             pa_ok_reg;
    crpa_pkg::refs_t  refs_rd_reg;

    // ---------------- result register ----------------
    logic              out_valid_reg;
    crpa_pkg::pair_t   res_pair_reg;
    crpa_pkg::color_t  res_fore_reg;
    crpa_pkg::color_t  res_back_reg;
    crpa_pkg::status_t res_status_reg;

    function automatic idx_t pair_to_idx(input crpa_pkg::pair_t p);
        logic [8:0] t;
        t = {2'b00, p} - 9'd1;
        return t[IDX_W-1:0];
    endfunction

    function automatic logic pair_in_range(input crpa_pkg::pair_t p);
        return ({2'b00, p} != 9'd0) && ({2'b00, p} <= SLOTS9);
    endfunction

    function automatic crpa_pkg::pair_t idx_to_pair(input idx_t i);
        logic [8:0] t;
        t = 9'(i) + 9'd1;
        return t[crpa_pkg::PAIR_W-1:0];
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pairs_reg <= crpa_pkg::MAX_PAIRS_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_pairs_reg <= cfg_wr_data;
        end
    end

    // ---------------- capture and pair memory read ----------------
    idx_t rd_a_idx;
    idx_t rd_b_idx;

    always_comb
    begin
        rd_a_idx = pair_to_idx(pair_a);
        if (crpa_pkg::func_t'(func) == crpa_pkg::FUNC_LOOKUP)
        begin
            rd_b_idx = pair_to_idx(pair_a);
        end
        else
        begin
            rd_b_idx = pair_to_idx(pair_b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= crpa_pkg::func_t'(func);
            fg_reg      <= fore_color;
            bg_reg      <= back_color;
            pa_reg      <= pair_a;
            pb_reg      <= pair_b;
            rd_fore_reg <= mem_fore[rd_a_idx];
            rd_back_reg <= mem_back[rd_b_idx];
        end
    end

    // ---------------- match step ----------------
    idx_t             pa_idx;
    idx_t             pb_idx;
    logic             pa_ok;
    logic             pb_ok;
    crpa_pkg::color_t eff_fg;
    crpa_pkg::color_t eff_bg;
    logic             hit;
    idx_t             hit_idx;
    logic             free_ok;
    idx_t             free_idx;

    always_comb
    begin
        pa_idx = pair_to_idx(pa_reg);
        pb_idx = pair_to_idx(pb_reg);
        pa_ok  = pair_in_range(pa_reg) && valid_reg[pa_idx];
        pb_ok  = pair_in_range(pb_reg) && valid_reg[pb_idx];
        if (func_reg == crpa_pkg::FUNC_COMBINE)
        begin
            eff_fg = pa_ok ? rd_fore_reg : crpa_pkg::TERM_DEFAULT_COLOR;
            eff_bg = pb_ok ? rd_back_reg : crpa_pkg::TERM_DEFAULT_COLOR;
        end
        else
        begin
            eff_fg = fg_reg;
            eff_bg = bg_reg;
        end
    end

    // Parallel compare in every slot cell, lowest index wins.
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_ok  = 1'b0;
        free_idx = '0;
        for (int s = TABLE_SLOTS - 1; s >= 0; s--)
        begin
            if (valid_reg[s] && (cell_fore_reg[s] == eff_fg) && (cell_back_reg[s] == eff_bg))
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(s);
            end
            if (!valid_reg[s])
            begin
                free_ok  = 1'b1;
                free_idx = IDX_W'(s);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.evaluate)
        begin
            ev_fg_reg    <= eff_fg;
            ev_bg_reg    <= eff_bg;
            hit_reg      <= hit;
            hit_idx_reg  <= hit_idx;
            free_ok_reg  <= free_ok;
            free_idx_reg <= free_idx;
            pa_ok_reg    <= pa_ok;
            refs_rd_reg  <= mem_refs[hit_idx];
        end
    end

    // ---------------- update step ----------------
    logic [8:0]        limit;
    logic              room;
    logic              set_valid;
    logic              clr_valid;
    logic              wr_refs;
    idx_t              wr_refs_idx;
    crpa_pkg::refs_t   wr_refs_val;
    crpa_pkg::refs_t   refs_dec;
    crpa_pkg::pair_t   res_pair;
    crpa_pkg::color_t  res_fore;
    crpa_pkg::color_t  res_back;
    crpa_pkg::status_t res_status;

    always_comb
    begin
        limit       = ({2'b00, max_pairs_reg} > SLOTS9) ? SLOTS9 : {2'b00, max_pairs_reg};
        room        = ({2'b00, piu_reg} < limit) && free_ok_reg;
        refs_dec    = (refs_rd_reg == '0) ? '0 : refs_rd_reg - 16'd1;
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        wr_refs     = 1'b0;
        wr_refs_idx = hit_idx_reg;
        wr_refs_val = refs_rd_reg;
        piu_next    = piu_reg;
        res_pair    = '0;
        res_fore    = crpa_pkg::TERM_DEFAULT_COLOR;
        res_back    = crpa_pkg::TERM_DEFAULT_COLOR;
        res_status  = crpa_pkg::ST_NOT_FOUND;
        case (func_reg)
            crpa_pkg::FUNC_ALLOC, crpa_pkg::FUNC_COMBINE:
            begin
                if ((func_reg == crpa_pkg::FUNC_COMBINE)
                    && (ev_fg_reg == crpa_pkg::TERM_DEFAULT_COLOR)
                    && (ev_bg_reg == crpa_pkg::TERM_DEFAULT_COLOR))
                begin
                    res_status = crpa_pkg::ST_NORMAL;
                end
                else if (hit_reg)
                begin
                    wr_refs     = 1'b1;
                    wr_refs_val = (refs_rd_reg == crpa_pkg::REFS_MAX) ? refs_rd_reg
                                                                       : refs_rd_reg + 16'd1;
                    res_pair    = idx_to_pair(hit_idx_reg);
                    res_fore    = ev_fg_reg;
                    res_back    = ev_bg_reg;
                    res_status  = crpa_pkg::ST_REUSED;
                end
                else if (room)
                begin
                    set_valid   = 1'b1;
                    wr_refs     = 1'b1;
                    wr_refs_idx = free_idx_reg;
                    wr_refs_val = 16'd1;
                    piu_next    = piu_reg + 7'd1;
                    res_pair    = idx_to_pair(free_idx_reg);
                    res_fore    = ev_fg_reg;
                    res_back    = ev_bg_reg;
                    res_status  = crpa_pkg::ST_NEW;
                end
                else
                begin
                    res_status = crpa_pkg::ST_FULL;
                end
            end
            crpa_pkg::FUNC_FREE:
            begin
                if (hit_reg)
                begin
                    wr_refs     = 1'b1;
                    wr_refs_val = refs_dec;
                    res_pair    = idx_to_pair(hit_idx_reg);
                    res_fore    = ev_fg_reg;
                    res_back    = ev_bg_reg;
                    if (refs_dec != '0)
                    begin
                        res_status = crpa_pkg::ST_HELD;
                    end
                    else
                    begin
                        clr_valid  = 1'b1;
                        piu_next   = (piu_reg == '0) ? piu_reg : piu_reg - 7'd1;
                        res_status = crpa_pkg::ST_RELEASED;
                    end
                end
            end
            crpa_pkg::FUNC_LOOKUP:
            begin
                if (pa_ok_reg)
                begin
                    res_pair   = pa_reg;
                    res_fore   = rd_fore_reg;
                    res_back   = rd_back_reg;
                    res_status = crpa_pkg::ST_REUSED;
                end
            end
            default:
            begin
                res_status = crpa_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            piu_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            piu_reg <= piu_next;
            if (set_valid)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && set_valid)
        begin
            cell_fore_reg[free_idx_reg] <= ev_fg_reg;
            cell_back_reg[free_idx_reg] <= ev_bg_reg;
            mem_fore[free_idx_reg]      <= ev_fg_reg;
            mem_back[free_idx_reg]      <= ev_bg_reg;
        end
        if (cmd.commit && wr_refs)
        begin
            mem_refs[wr_refs_idx] <= wr_refs_val;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_pair_reg   <= res_pair;
            res_fore_reg   <= res_fore;
            res_back_reg   <= res_back;
            res_status_reg <= res_status;
        end
    end

    assign sts.out_busy = out_valid_reg && out_stall;
    assign out_valid    = out_valid_reg;
    assign pair_index   = res_pair_reg;
    assign fore_out     = res_fore_reg;
    assign back_out     = res_back_reg;
    assign status       = res_status_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        piu_reg == 7'($countones(valid_reg)))
        else $error("pairs in use disagrees with the number of valid slots");

    a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("update step did not present a result word");

    a_no_commit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("update committed over a waiting result word");

endmodule

@@ sv/refcounted_color_pair_allocator_core.sv @@
// Top level of the reference-counted color pair allocator.
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ---------------------------------------
//  in        input      in_valid / in_stall        func, fore_color, back_color, pair_a, pair_b
//  out       output     out_valid / out_stall      pair_index, fore_out, back_out, status
//  cfg       input      cfg_wr_en                  cfg_wr_data (max_pairs)
//
// Each word passes through the accept step (which also reads the pair memory at
// pair_a and pair_b), the match step (all slot cells compare in parallel, priority
// encoders pick the matching and the lowest free slot, the count memory is read), and
// the update step that writes the table and loads the result register.
// The next word can be taken in the cycle after the update; no new word is accepted
// while one is in the match or update step. A stalled output holds the update step
// until the result register drains. Reset clears all slots, the in-use count and the
// limit (back to 64); no clearing pass is needed.
module refcounted_color_pair_allocator_core
#(
    parameter int TABLE_SLOTS = crpa_pkg::TABLE_SLOTS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [crpa_pkg::PAIR_W-1:0]          cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [crpa_pkg::FUNC_W-1:0]          func,
    input  logic signed [crpa_pkg::COLOR_W-1:0]  fore_color,
    input  logic signed [crpa_pkg::COLOR_W-1:0]  back_color,
    input  logic [crpa_pkg::PAIR_W-1:0]          pair_a,
    input  logic [crpa_pkg::PAIR_W-1:0]          pair_b,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [crpa_pkg::PAIR_W-1:0]          pair_index,
    output logic signed [crpa_pkg::COLOR_W-1:0]  fore_out,
    output logic signed [crpa_pkg::COLOR_W-1:0]  back_out,
    output logic [crpa_pkg::STATUS_W-1:0]        status
);

    // The controller only sequences the word; every table access lives in the datapath.
    crpa_pkg::ctl_cmd_t   cmd;
    crpa_pkg::dp_status_t sts;

    crpa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Slot table, pair and count memories, and the result register.
    crpa_datapath
    #(
        .TABLE_SLOTS (TABLE_SLOTS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .func        (func),
        .fore_color  (fore_color),
        .back_color  (back_color),
        .pair_a      (pair_a),
        .pair_b      (pair_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pair_index  (pair_index),
        .fore_out    (fore_out),
        .back_out    (back_out),
        .status      (status)
    );

endmodule

@@ verif/crpa_check_pkg.sv @@
// Scoreboard class that predicts and checks the result words of the color pair allocator.
package crpa_check_pkg;

    import crpa_pkg::*;

    typedef struct packed {
        pair_t   idx;
        color_t  fore;
        color_t  back;
        status_t st;
    } pair_result_t;

    class pair_table_scoreboard;

        bit           live [TABLE_SLOTS_DEF];
        color_t       fg_of [TABLE_SLOTS_DEF];
        color_t       bg_of [TABLE_SLOTS_DEF];
        refs_t        ref_count [TABLE_SLOTS_DEF];
        pair_t        live_count;
        pair_t        limit_reg;
        pair_result_t owed_results [$];
        int           mismatches;

        function new();
            foreach (live[s])
            begin
                live[s]      = 1'b0;
                fg_of[s]     = '0;
                bg_of[s]     = '0;
                ref_count[s] = '0;
            end
            live_count = '0;
            limit_reg  = MAX_PAIRS_RESET;
            mismatches = 0;
        endfunction

        function void set_limit(pair_t v);
            limit_reg = v;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function pair_result_t outcome(int idx, color_t fg, color_t bg, status_t st);
            pair_result_t r;
            r.idx  = pair_t'(idx);
            r.fore = fg;
            r.back = bg;
            r.st   = st;
            return r;
        endfunction

        function int find_slot(color_t fg, color_t bg);
            for (int s = 0; s < TABLE_SLOTS_DEF; s++)
            begin
                if (live[s] && fg_of[s] == fg && bg_of[s] == bg)
                    return s;
            end
            return -1;
        endfunction

        // Slot behind a pair index, or -1 when the index names no live pair.
        function int slot_of_pair(pair_t p);
            if (p == 0 || int'(p) > TABLE_SLOTS_DEF)
                return -1;
            if (!live[int'(p) - 1])
                return -1;
            return int'(p) - 1;
        endfunction

        function pair_result_t allocate(color_t fg, color_t bg);
            int s;
            int cap;
            cap = (int'(limit_reg) < TABLE_SLOTS_DEF) ? int'(limit_reg) : TABLE_SLOTS_DEF;
            s = find_slot(fg, bg);
            if (s >= 0)
            begin
                if (ref_count[s] != REFS_MAX)
                    ref_count[s] = ref_count[s] + 16'd1;
                return outcome(s + 1, fg, bg, ST_REUSED);
            end
            if (int'(live_count) < cap)
            begin
                for (s = 0; s < TABLE_SLOTS_DEF; s++)
                begin
                    if (!live[s])
                    begin
                        live[s]      = 1'b1;
                        fg_of[s]     = fg;
                        bg_of[s]     = bg;
                        ref_count[s] = 16'd1;
                        live_count   = live_count + 7'd1;
                        return outcome(s + 1, fg, bg, ST_NEW);
                    end
                end
            end
            return outcome(0, TERM_DEFAULT_COLOR, TERM_DEFAULT_COLOR, ST_FULL);
        endfunction

        function pair_result_t release_pair(color_t fg, color_t bg);
            int s;
            s = find_slot(fg, bg);
            if (s < 0)
                return outcome(0, TERM_DEFAULT_COLOR, TERM_DEFAULT_COLOR, ST_NOT_FOUND);
            if (ref_count[s] != 0)
                ref_count[s] = ref_count[s] - 16'd1;
            if (ref_count[s] != 0)
                return outcome(s + 1, fg, bg, ST_HELD);
            live[s] = 1'b0;
            if (live_count != 0)
                live_count = live_count - 7'd1;
            return outcome(s + 1, fg, bg, ST_RELEASED);
        endfunction

        function void note_word(func_t f, color_t fg, color_t bg, pair_t pa, pair_t pb);
            pair_result_t r;
            int     sa;
            int     sb;
            color_t cf;
            color_t cb;
            case (f)
                FUNC_ALLOC:
                    r = allocate(fg, bg);
                FUNC_FREE:
                    r = release_pair(fg, bg);
                FUNC_LOOKUP:
                begin
                    sa = slot_of_pair(pa);
                    if (sa < 0)
                        r = outcome(0, TERM_DEFAULT_COLOR, TERM_DEFAULT_COLOR, ST_NOT_FOUND);
                    else
                        r = outcome(int'(pa), fg_of[sa], bg_of[sa], ST_REUSED);
                end
                default:
                begin
                    sa = slot_of_pair(pa);
                    sb = slot_of_pair(pb);
                    cf = (sa >= 0) ? fg_of[sa] : TERM_DEFAULT_COLOR;
                    cb = (sb >= 0) ? bg_of[sb] : TERM_DEFAULT_COLOR;
                    if (cf == TERM_DEFAULT_COLOR && cb == TERM_DEFAULT_COLOR)
                        r = outcome(0, TERM_DEFAULT_COLOR, TERM_DEFAULT_COLOR, ST_NORMAL);
                    else
                        r = allocate(cf, cb);
                end
            endcase
            owed_results.push_back(r);
        endfunction

        function void check_result(pair_t idx, color_t fg, color_t bg, logic [2:0] st);
            pair_result_t want;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: pair %0d fg %0d bg %0d status %0d",
                             idx, fg, bg, st);
                return;
            end
            want = owed_results.pop_front();
            if (idx !== want.idx || fg !== want.fore || bg !== want.back || st !== want.st)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected pair %0d fg %0d bg %0d status %0d, %s",
                             want.idx, $signed(want.fore), $signed(want.back), want.st,
                             $sformatf("got pair %0d fg %0d bg %0d status %0d",
                                       idx, fg, bg, st));
            end
        endfunction

    endclass

endpackage

@@ verif/refcounted_color_pair_allocator_core_tb.sv @@
// Self-checking testbench of the reference-counted color pair allocator core.
module refcounted_color_pair_allocator_core_tb;

    import crpa_pkg::*;
    import crpa_check_pkg::*;

    // Cycles with no handshake on either channel before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    // A word passes through the capture, match and update steps inside the block, so the
    // drain wait after the last result is long enough to catch a stray extra word.
    localparam int DRAIN_CYCLES    = 12;
    localparam int PHASE_WORDS     = 185;

    logic   clk;
    logic   rst_n;
    logic   cfg_wr_en;
    pair_t  cfg_wr_data;
    logic   in_valid;
    logic   in_stall;
    logic [FUNC_W-1:0] func;
    color_t fore_color;
    color_t back_color;
    pair_t  pair_a;
    pair_t  pair_b;
    logic   out_valid;
    logic   out_stall;
    pair_t  pair_index;
    color_t fore_out;
    color_t back_out;
    logic [STATUS_W-1:0] status;

    pair_table_scoreboard ledger = new();

    int idle_cycles = 0;
    int burst_left  = 0;
    bit hold_req    = 1'b0;

    // Colors handed out by allocate words and not yet freed, so that most frees
    // of the random part hit a live pair.
    color_t live_fore [$];
    color_t live_back [$];

    // A small pool keeps pairs repeating, which is what drives reuse and frees.
    // Its 64 combinations also match the table size, so the table can fill up.
    color_t color_pool [8] = '{TERM_DEFAULT_COLOR, -9'sd1, 9'sd0, 9'sd1, 9'sd15,
                               9'sd128, 9'sd200, 9'sd255};

    // The 7 and 17 settings together with 40 and 64 toggle every register bit.
    pair_t phase_limits [7] = '{7'd64, 7'd7, 7'd0, 7'd17, 7'd64, 7'd1, 7'd40};

    refcounted_color_pair_allocator_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .fore_color  (fore_color),
        .back_color  (back_color),
        .pair_a      (pair_a),
        .pair_b      (pair_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pair_index  (pair_index),
        .fore_out    (fore_out),
        .back_out    (back_out),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Every handshake is sampled at the rising edge, where all testbench drives
    // still hold their pre-edge values because they are nonblocking. Config
    // writes, accepted input words and accepted result words all pass through
    // here, so the scoreboard sees them in true clock order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                ledger.set_limit(cfg_wr_data);
            if (in_valid && !in_stall)
                ledger.note_word(func_t'(func), fore_color, back_color, pair_a, pair_b);
            if (out_valid && !out_stall)
                ledger.check_result(pair_index, fore_out, back_out, status);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("[refcounted_color_pair_allocator_core] ERROR");
                $finish;
            end
        end
    end

    // Receiver: runs of random length, each with its own stall density, from
    // never stalling through alternate cycles to nearly always stalling. Once the
    // stimulus asks for it, the receiver holds off for a long stretch so that
    // the result register backs up and the block stalls its input.
    initial
    begin
        int run;
        int odds;
        int mode;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                run  = $urandom_range(4, 60);
                mode = $urandom_range(0, 4);
                case (mode)
                    0: odds = 0;
                    1: odds = 30;
                    2: odds = 60;
                    3: odds = 85;
                    default: odds = -1;
                endcase
                for (int c = 0; c < run; c++)
                begin
                    if (odds < 0)
                        out_stall <= c[0];
                    else
                        out_stall <= ($urandom_range(0, 99) < odds);
                    @(posedge clk);
                end
            end
        end
    end

    // Sender pacing: after each accepted word either stay in the current burst
    // or drop valid for a random gap and start a new burst.
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Offer one word and hold it steady until the block takes it.
    task automatic send_word(func_t f, color_t fg, color_t bg, pair_t pa, pair_t pb);
        in_valid   <= 1'b1;
        func       <= f;
        fore_color <= fg;
        back_color <= bg;
        pair_a     <= pa;
        pair_b     <= pb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pace();
    endtask

    // Drop valid and wait until every owed result word has come back. The
    // extra edge first makes sure the last accepted word has been noted.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(pair_t v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic color_t pick_color();
        if ($urandom_range(0, 4) != 0)
            return color_pool[$urandom_range(0, 7)];
        return color_t'($urandom_range(0, 255));
    endfunction

    // Live pairs sit at the low indexes, so lookups and combines aim there most
    // of the time and cover the whole index range the rest of the time.
    function automatic pair_t pick_pair();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return pair_t'($urandom_range(1, 12));
        if (roll == 7)
            return '0;
        return pair_t'($urandom_range(0, 64));
    endfunction

    task automatic random_word();
        int     roll;
        int     k;
        color_t fg;
        color_t bg;
        roll = $urandom_range(0, 99);
        fg   = pick_color();
        bg   = pick_color();
        if (roll < 40)
        begin
            live_fore.push_back(fg);
            live_back.push_back(bg);
            send_word(FUNC_ALLOC, fg, bg, pick_pair(), pick_pair());
        end
        else if (roll < 70)
        begin
            // Mostly a matching free of an earlier allocation, sometimes a stray one.
            if (live_fore.size() != 0 && $urandom_range(0, 4) != 0)
            begin
                k  = $urandom_range(0, live_fore.size() - 1);
                fg = live_fore[k];
                bg = live_back[k];
                live_fore.delete(k);
                live_back.delete(k);
            end
            send_word(FUNC_FREE, fg, bg, pick_pair(), pick_pair());
        end
        else if (roll < 85)
            send_word(FUNC_LOOKUP, fg, bg, pick_pair(), pick_pair());
        else
            send_word(FUNC_COMBINE, fg, bg, pick_pair(), pick_pair());
    endtask

    // Hand-picked words: empty-table lookups and combines, a new pair on the
    // default colors, reuse, combines from valid and missing pairs (including
    // two default colors taken from live pairs), frees down to release and past
    // it, and reuse of the lowest freed index. With the limit at zero, new pairs
    // come back full while hits on live pairs still succeed.
    task automatic run_directed();
        send_word(FUNC_LOOKUP,  9'sd0, 9'sd0, 7'd0, 7'd0);
        send_word(FUNC_LOOKUP,  9'sd0, 9'sd0, 7'd64, 7'd0);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd0, 7'd64);
        send_word(FUNC_FREE,    9'sd5, 9'sd5, 7'd0, 7'd0);
        send_word(FUNC_ALLOC,   TERM_DEFAULT_COLOR, TERM_DEFAULT_COLOR, 7'd0, 7'd0);
        send_word(FUNC_ALLOC,   9'sd255, 9'sd0, 7'd0, 7'd0);
        send_word(FUNC_ALLOC,   9'sd255, 9'sd0, 7'd0, 7'd0);
        send_word(FUNC_ALLOC,   -9'sd1, 9'sd255, 7'd0, 7'd0);
        send_word(FUNC_LOOKUP,  9'sd0, 9'sd0, 7'd2, 7'd0);
        send_word(FUNC_LOOKUP,  9'sd0, 9'sd0, 7'd1, 7'd0);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd1, 7'd1);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd2, 7'd3);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd3, 7'd0);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd0, 7'd2);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd2, 7'd2);
        repeat (4) send_word(FUNC_FREE, 9'sd255, 9'sd0, 7'd0, 7'd0);
        send_word(FUNC_ALLOC,   9'sd0, 9'sd128, 7'd0, 7'd0);
        send_word(FUNC_LOOKUP,  9'sd0, 9'sd0, 7'd2, 7'd0);

        settle();
        write_limit(7'd0);
        send_word(FUNC_ALLOC,   9'sd1, 9'sd1, 7'd0, 7'd0);
        send_word(FUNC_ALLOC,   TERM_DEFAULT_COLOR, TERM_DEFAULT_COLOR, 7'd0, 7'd0);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd3, 7'd4);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd4, 7'd3);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd2, 7'd1);
    endtask

    // Fill the whole table with distinct pairs until it reports full, look at
    // the topmost slot, then free everything again.
    task automatic fill_and_drain();
        for (int i = 0; i <= TABLE_SLOTS_DEF; i++)
            send_word(FUNC_ALLOC, color_t'(i), 9'sd77, pick_pair(), pick_pair());
        send_word(FUNC_LOOKUP,  9'sd0, 9'sd0, 7'd64, 7'd0);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd64, 7'd64);
        send_word(FUNC_COMBINE, 9'sd0, 9'sd0, 7'd64, 7'd1);
        for (int i = 0; i <= TABLE_SLOTS_DEF; i++)
            send_word(FUNC_FREE, color_t'(i), 9'sd77, pick_pair(), pick_pair());
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        func        <= FUNC_ALLOC;
        fore_color  <= '0;
        back_color  <= '0;
        pair_a      <= '0;
        pair_b      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        settle();
        write_limit(7'd64);
        fill_and_drain();

        // Random phases, each under its own allocation limit. The first one
        // starts with the long receiver hold-off while words keep coming.
        foreach (phase_limits[p])
        begin
            settle();
            write_limit(phase_limits[p]);
            if (p == 0)
                hold_req = 1'b1;
            repeat (PHASE_WORDS) random_word();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("[refcounted_color_pair_allocator_core] OK");
        else
            $display("[refcounted_color_pair_allocator_core] ERROR");
        $finish;
    end

endmodule
